// File: src/acss_pkg.sv
// Shared types, constants and helpers for the caseless substring search unit.
package acss_pkg;

    localparam int NEEDLE_CAP       = 16;
    localparam int NEEDLE_MAX_DEF   = 16;
    localparam longint unsigned HAYSTACK_MAX_DEF = 64'd65536;

    localparam int LEN_W      = 5;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd2;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [NEEDLE_CAP-1:0][7:0] folded;
        logic [LEN_W-1:0]           len;
    } needle_t;

    function automatic byte_t fold_case(input byte_t b);
        byte_t r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// File: src/acss_if.sv
// Request and result channel interfaces.
interface acss_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] haystack_byte;
    logic       end_marker;

    modport source (output valid, output haystack_byte, output end_marker, input ready);
    modport sink   (input valid, input haystack_byte, input end_marker, output ready);
endinterface

interface acss_res_if;
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [acss_pkg::POS_W-1:0] match_position;
    logic                     length_exceeded;

    modport source (output valid, output found, output match_position,
                    output length_exceeded, input ready);
    modport sink   (input valid, input found, input match_position,
                    input length_exceeded, output ready);
endinterface

// File: src/ascii_caseless_substring_search_unit.sv
// Top level of the caseless substring search unit.
//
// Usage:
//   req carries one haystack byte per request; a request with end_marker set
//   closes the haystack (its byte is ignored). res carries one result per
//   haystack: found with match_position at the byte that starts the first
//   match, or found=0 (length_exceeded set if the haystack overran) at the
//   end request. An empty needle matches at position 0 on the first request.
//   The needle is set through cfg_we/cfg_index/cfg_data while no haystack
//   is in flight; a register index beyond REG_NEEDLE_LEN is ignored.
// Pipeline:
//   One request per cycle while req.ready is high. A request that is taken
//   passes through the input register, then through the compare of the folded
//   window against the needle into the result register.
// Reset clears the window, the byte counter, the needle and the valid bits
// of both registers. When res is stalled the result register holds; the input
// register keeps its request until the result register is free, so req.ready
// falls only while both are full.
module ascii_caseless_substring_search_unit #(
    parameter int              NEEDLE_MAX   = acss_pkg::NEEDLE_MAX_DEF,
    parameter longint unsigned HAYSTACK_MAX = acss_pkg::HAYSTACK_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [acss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [acss_pkg::CFG_DATA_W-1:0]  cfg_data,
    acss_req_if.sink                        req,
    acss_res_if.source                      res
);
    import acss_pkg::*;

    localparam int WIN = (NEEDLE_MAX < NEEDLE_CAP) ? NEEDLE_MAX : NEEDLE_CAP;
    localparam int CW  = $clog2(HAYSTACK_MAX + 64'd1);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(HAYSTACK_MAX);

    needle_t needle;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg,  s1_byte_next;
    logic        s1_end_reg,   s1_end_next;

    logic [WIN-1:0][7:0] win_reg, win_next, win_shift;
    logic [CW-1:0]       count_reg, count_next, count_inc;
    logic                given_reg, given_next;
    logic                sat_reg,   sat_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [POS_W-1:0]  out_pos_reg,   out_pos_next;
    logic              out_exc_reg,   out_exc_next;

    logic       out_free;
    logic       proc;
    logic       hit;
    logic [PW-1:0] pos_full;

    acss_cfg #(.NEEDLE_MAX(NEEDLE_MAX)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .needle    (needle)
    );

    acss_match #(.NEEDLE_MAX(NEEDLE_MAX)) u_match (
        .window (win_shift),
        .needle (needle),
        .hit    (hit)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign proc      = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;

    assign count_inc = count_reg + CW'(1);
    assign pos_full  = PW'(count_inc) - PW'(needle.len);

    always_comb
    begin
        win_shift[0] = fold_case(s1_byte_reg);
        for (int i = 1; i < WIN; i++)
        begin
            win_shift[i] = win_reg[i-1];
        end
    end

    // input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_byte_next  = s1_byte_reg;
        s1_end_next   = s1_end_reg;
        if (req.valid && req.ready)
        begin
            s1_valid_next = 1'b1;
            s1_byte_next  = req.haystack_byte;
            s1_end_next   = req.end_marker;
        end
        else if (proc)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // search state and result
    always_comb
    begin
        win_next       = win_reg;
        count_next     = count_reg;
        given_next     = given_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        out_exc_next   = out_exc_reg;
        if (proc)
        begin
            if (s1_end_reg)
            begin
                if (!given_reg)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = (needle.len == '0);
                    out_pos_next   = '0;
                    out_exc_next   = (needle.len != '0) && sat_reg;
                end
                win_next   = '0;
                count_next = '0;
                given_next = 1'b0;
                sat_next   = 1'b0;
            end
            else if (given_reg)
            begin
            end
            else if (needle.len == '0)
            begin
                given_next     = 1'b1;
                out_valid_next = 1'b1;
                out_found_next = 1'b1;
                out_pos_next   = '0;
                out_exc_next   = 1'b0;
            end
            else if (sat_reg)
            begin
            end
            else if (count_reg == COUNT_LIMIT)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                win_next   = win_shift;
                count_next = count_inc;
                if (count_inc >= CW'(needle.len) && hit)
                begin
                    given_next     = 1'b1;
                    out_valid_next = 1'b1;
                    out_found_next = 1'b1;
                    out_pos_next   = pos_full[POS_W-1:0];
                    out_exc_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            win_reg       <= '0;
            count_reg     <= '0;
            given_reg     <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            win_reg       <= win_next;
            count_reg     <= count_next;
            given_reg     <= given_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_byte_reg   <= s1_byte_next;
        s1_end_reg    <= s1_end_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
        out_exc_reg   <= out_exc_next;
    end

    assign res.valid           = out_valid_reg;
    assign res.found           = out_found_reg;
    assign res.match_position  = out_pos_reg;
    assign res.length_exceeded = out_exc_reg;

endmodule

// File: src/acss_cfg.sv
// Needle register file, case folding and effective length.
module acss_cfg #(
    parameter int NEEDLE_MAX = acss_pkg::NEEDLE_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [acss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acss_pkg::CFG_DATA_W-1:0] cfg_data,
    output acss_pkg::needle_t              needle
);
    import acss_pkg::*;

    localparam int WIN = (NEEDLE_MAX < NEEDLE_CAP) ? NEEDLE_MAX : NEEDLE_CAP;

    logic [CFG_DATA_W-1:0] low_reg,  low_next;
    logic [CFG_DATA_W-1:0] high_reg, high_next;
    logic [LEN_W-1:0]      len_reg,  len_next;

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        len_next  = len_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NEEDLE_LOW:  low_next  = cfg_data;
                REG_NEEDLE_HIGH: high_next = cfg_data;
                REG_NEEDLE_LEN:  len_next  = cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            len_reg  <= '0;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
            len_reg  <= len_next;
        end
    end

    // needle stops at its first zero byte, length capped at the window
    always_comb
    begin
        logic [NEEDLE_CAP-1:0][7:0] raw;
        logic [LEN_W-1:0]           capped;
        logic [LEN_W-1:0]           eff;
        raw    = {high_reg, low_reg};
        capped = (len_reg > LEN_W'(WIN)) ? LEN_W'(WIN) : len_reg;
        eff    = capped;
        for (int i = NEEDLE_CAP - 1; i >= 0; i--)
        begin
            if (LEN_W'(i) < capped && raw[i] == 8'h00)
            begin
                eff = LEN_W'(i);
            end
        end
        for (int i = 0; i < NEEDLE_CAP; i++)
        begin
            needle.folded[i] = fold_case(raw[i]);
        end
        needle.len = eff;
    end

endmodule

// File: src/acss_match.sv
// Window against needle comparator.
module acss_match #(
    parameter int NEEDLE_MAX = acss_pkg::NEEDLE_MAX_DEF
) (
    input  logic [((NEEDLE_MAX < acss_pkg::NEEDLE_CAP) ? NEEDLE_MAX
                   : acss_pkg::NEEDLE_CAP)-1:0][7:0] window,
    input  acss_pkg::needle_t                        needle,
    output logic                                     hit
);
    import acss_pkg::*;

    localparam int WIN = (NEEDLE_MAX < NEEDLE_CAP) ? NEEDLE_MAX : NEEDLE_CAP;
    localparam int IW  = (WIN > 1) ? $clog2(WIN) : 1;

    // needle byte i lines up with window slot len-1-i (newest in slot 0)
    always_comb
    begin
        logic [LEN_W-1:0] slot;
        logic [IW-1:0]    sel;
        hit = 1'b1;
        for (int i = 0; i < WIN; i++)
        begin
            slot = needle.len - LEN_W'(i + 1);
            sel  = slot[IW-1:0];
            if (LEN_W'(i) < needle.len && window[sel] != needle.folded[i])
            begin
                hit = 1'b0;
            end
        end
    end

endmodule

// File: src/acss_checker.sv
// Port-level checks for the caseless substring search unit, with bind.
module acss_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic                      res_found,
    input logic [acss_pkg::POS_W-1:0] res_match_position,
    input logic                      res_length_exceeded
);
    import acss_pkg::*;

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_found)
            && $stable(res_match_position) && $stable(res_length_exceeded))
        else $error("result changed while stalled");

    a_found_not_exceeded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_found && res_length_exceeded))
        else $error("found and length_exceeded both set");

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> res_match_position == '0)
        else $error("nonzero position without a match");

    // a fresh result comes from a taken request, through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without a request two cycles before");

    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> req_ready)
        else $error("request stalled while result side is ready");

endmodule

bind ascii_caseless_substring_search_unit acss_checker u_acss_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .res_found           (res.found),
    .res_match_position  (res.match_position),
    .res_length_exceeded (res.length_exceeded)
);
